/* hw/rtl/bhp_pkg.sv */
// ----------------------------------------------------------------------------
// bhp_pkg
// Shared types, widths, command/status codes and the letter-to-dots table
// for the Braille history pager.
// ----------------------------------------------------------------------------
`default_nettype none

package bhp_pkg;

  // History store size and derived widths
  localparam int HISTORY_DEPTH = 512;
  localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  // cell index: window start plus up to four
  localparam int IDX_W         = $clog2(HISTORY_DEPTH + 5);
  // signed window start: holds -5 up to depth plus a page
  localparam int WS_W          = $clog2(HISTORY_DEPTH + 6) + 1;

  // Display geometry
  localparam int CELL_COUNT  = 5;
  localparam int CELL_W      = 6;
  localparam int PATTERN_W   = CELL_COUNT * CELL_W;
  localparam int PAGE_STEP   = 5;
  localparam int CELL_IDX_W  = 3;

  // Rescan timeout register
  localparam int TIMEOUT_W = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30000;

  localparam logic signed [WS_W-1:0] WS_STEP  = WS_W'(PAGE_STEP);
  localparam logic signed [WS_W-1:0] WS_RESET = WS_W'(-PAGE_STEP);

  // Command codes
  localparam logic [2:0] CMD_CHAR    = 3'd0;
  localparam logic [2:0] CMD_FORWARD = 3'd1;
  localparam logic [2:0] CMD_BACK    = 3'd2;
  localparam logic [2:0] CMD_CLEAR   = 3'd3;
  localparam logic [2:0] CMD_RESCAN  = 3'd4;
  localparam logic [2:0] CMD_TICK    = 3'd5;

  // Status codes
  localparam logic [3:0] STAT_OK          = 4'd0;
  localparam logic [3:0] STAT_EMPTY       = 4'd1;
  localparam logic [3:0] STAT_END         = 4'd2;
  localparam logic [3:0] STAT_BEGINNING   = 4'd3;
  localparam logic [3:0] STAT_DROPPED     = 4'd4;
  localparam logic [3:0] STAT_RESCAN_DONE = 4'd5;
  localparam logic [3:0] STAT_TIMEOUT     = 4'd6;
  localparam logic [3:0] STAT_CLEARED     = 4'd7;
  localparam logic [3:0] STAT_RESTORED    = 4'd8;

  // Request and result payloads
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_byte;
  } item_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] dot_pattern;
    logic                 pattern_update;
    logic [3:0]           status_code;
    logic                 rescan_request;
    logic                 rescan_pending;
  } result_t;

  // Dots 1..6 for letters a..z
  localparam logic [CELL_W-1:0] LETTER_DOTS [26] = '{
    6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
    6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
    6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
  };

  // Non-letters map to a blank cell
  function automatic logic [CELL_W-1:0] letter_dots(input logic [7:0] ch);
    logic [7:0]        off;
    logic [CELL_W-1:0] dots;
    off  = 8'd0;
    dots = '0;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      off  = ch - 8'h61;
      dots = LETTER_DOTS[off[4:0]];
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      off  = ch - 8'h41;
      dots = LETTER_DOTS[off[4:0]];
    end
    return dots;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bhp_history_ram.sv */
// ----------------------------------------------------------------------------
// bhp_history_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bhp_history_ram #(
  parameter int DEPTH  = 512,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/bhp_render.sv */
// ----------------------------------------------------------------------------
// bhp_render
// Window renderer: walks the five cells of the window one RAM read per
// cycle through a single letter decoder and assembles the dot pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module bhp_render (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [bhp_pkg::IDX_W-1:0]     start_idx,
  input  wire logic [bhp_pkg::CNT_W-1:0]     count,
  output logic      [bhp_pkg::ADDR_W-1:0]    rd_addr,
  input  wire logic [7:0]                    rd_data,
  output logic                               done,
  output logic      [bhp_pkg::PATTERN_W-1:0] pattern
);

  import bhp_pkg::*;

  localparam logic [CELL_IDX_W-1:0] LAST_CELL = CELL_IDX_W'(CELL_COUNT - 1);
  localparam logic [CELL_IDX_W-1:0] NUM_CELLS = CELL_IDX_W'(CELL_COUNT);

  logic                            busy;
  logic [CELL_IDX_W-1:0]           issue_k;
  logic [IDX_W-1:0]                idx;
  logic                            pend_valid;
  logic [CELL_IDX_W-1:0]           pend_cell;
  logic                            pend_show;
  logic [CELL_COUNT-1:0][CELL_W-1:0] cells;

  assign rd_addr = idx[ADDR_W-1:0];
  assign pattern = cells;

  // issue sequencer: one cell address per cycle, collected in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      issue_k    <= '0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= busy && pend_valid && (pend_cell == LAST_CELL);
      if (start) begin
        busy       <= 1'b1;
        issue_k    <= '0;
        pend_valid <= 1'b0;
      end else if (busy) begin
        if (issue_k < NUM_CELLS) begin
          pend_valid <= 1'b1;
          issue_k    <= issue_k + 1'b1;
        end else begin
          pend_valid <= 1'b0;
        end
        if (pend_valid && pend_cell == LAST_CELL) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // index and pending-cell payload
  always_ff @(posedge clk) begin
    if (start) begin
      idx <= start_idx;
    end else if (busy && issue_k < NUM_CELLS) begin
      pend_cell <= issue_k;
      pend_show <= (idx < IDX_W'(count));
      idx       <= idx + 1'b1;
    end
  end

  // shared decoder writes one cell per cycle
  always_ff @(posedge clk) begin
    if (busy && pend_valid) begin
      cells[pend_cell] <= pend_show ? letter_dots(rd_data) : '0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/braille_history_pager_unit.sv */
// ----------------------------------------------------------------------------
// braille_history_pager_unit
// Appends received characters to a history RAM, pages a five-cell Braille
// window over it and handles the clear/restore and rescan/timeout flow.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------
//   item     | item_valid / item_stall   | bhp_pkg::item_t
//   result   | result_valid / result_stall | bhp_pkg::result_t
//   cfg      | cfg_valid / cfg_ready     | rescan timeout, 16 bit
//
// A request without a redraw goes from accept straight to ST_DONE.
// A redraw first passes through ST_DRAW: the renderer reads the
// five window cells one per cycle from the single RAM read port.
// item_stall is high from accept until the result is loaded into the
// output register; a stalled result holds while the next request enters.
// rst is synchronous; history is emptied and the window sits at -5.
// ----------------------------------------------------------------------------
`default_nettype none

module braille_history_pager_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire bhp_pkg::item_t                  item,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output bhp_pkg::result_t                     result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bhp_pkg::TIMEOUT_W-1:0]   cfg_data
);

  import bhp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DRAW = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        stored_count;
  logic signed [WS_W-1:0]  window_start;
  logic                    display_blanked;
  logic                    waiting_for_data;
  logic [TIMEOUT_W-1:0]    wait_elapsed;
  logic [TIMEOUT_W-1:0]    timeout_ticks;
  logic [PATTERN_W-1:0]    shown_pattern;
  logic                    res_update;
  logic [3:0]              res_status;
  logic                    res_request;

  // next values from the decoded request
  logic [CNT_W-1:0]        stored_count_next;
  logic signed [WS_W-1:0]  window_start_next;
  logic                    display_blanked_next;
  logic                    waiting_for_data_next;
  logic [TIMEOUT_W-1:0]    wait_elapsed_next;
  logic                    clear_pattern;
  logic                    update_now;
  logic [3:0]              status_now;
  logic                    request_now;
  logic                    draw_now;
  logic                    wr_en;

  logic signed [WS_W-1:0]  count_s;
  logic signed [WS_W-1:0]  ws_fwd;
  logic signed [WS_W-1:0]  ws_back;
  logic [TIMEOUT_W:0]      tick_next;

  logic                    accept;
  logic                    rend_start;
  logic                    rend_done;
  logic [PATTERN_W-1:0]    rend_pattern;
  logic [ADDR_W-1:0]       rd_addr;
  logic [7:0]              rd_data;
  logic                    out_free;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;
  assign rend_start = accept && draw_now;

  assign count_s   = WS_W'(stored_count);
  assign ws_fwd    = window_start + WS_STEP;
  assign ws_back   = window_start - WS_STEP;
  assign tick_next = {1'b0, wait_elapsed} + 1'b1;

  // command decode
  always_comb begin
    stored_count_next     = stored_count;
    window_start_next     = window_start;
    display_blanked_next  = display_blanked;
    waiting_for_data_next = waiting_for_data;
    wait_elapsed_next     = wait_elapsed;
    clear_pattern         = 1'b0;
    update_now            = 1'b0;
    status_now            = STAT_OK;
    request_now           = 1'b0;
    draw_now              = 1'b0;
    wr_en                 = 1'b0;
    case (item.command)
      CMD_CHAR: begin
        if (stored_count < CNT_W'(HISTORY_DEPTH)) begin
          wr_en             = accept;
          stored_count_next = stored_count + 1'b1;
        end else begin
          status_now = STAT_DROPPED;
        end
        if (waiting_for_data) begin
          waiting_for_data_next = 1'b0;
          status_now            = STAT_RESCAN_DONE;
        end
      end
      CMD_FORWARD: begin
        if (stored_count == '0) begin
          status_now = STAT_EMPTY;
        end else if (ws_fwd < count_s) begin
          window_start_next    = ws_fwd;
          draw_now             = !ws_fwd[WS_W-1];
          display_blanked_next = 1'b0;
        end else begin
          status_now = STAT_END;
        end
      end
      CMD_BACK: begin
        if (stored_count == '0) begin
          status_now = STAT_EMPTY;
        end else if (!ws_back[WS_W-1]) begin
          window_start_next    = ws_back;
          draw_now             = (ws_back < count_s);
          display_blanked_next = 1'b0;
        end else begin
          status_now = STAT_BEGINNING;
        end
      end
      CMD_CLEAR: begin
        if (!display_blanked) begin
          clear_pattern        = 1'b1;
          update_now           = 1'b1;
          display_blanked_next = 1'b1;
          status_now           = STAT_CLEARED;
        end else begin
          draw_now             = !window_start[WS_W-1] && (window_start < count_s);
          display_blanked_next = 1'b0;
          status_now           = STAT_RESTORED;
        end
      end
      CMD_RESCAN: begin
        stored_count_next     = '0;
        window_start_next     = WS_RESET;
        clear_pattern         = 1'b1;
        update_now            = 1'b1;
        request_now           = 1'b1;
        waiting_for_data_next = 1'b1;
        wait_elapsed_next     = '0;
      end
      CMD_TICK: begin
        if (waiting_for_data) begin
          if (tick_next > {1'b0, timeout_ticks}) begin
            waiting_for_data_next = 1'b0;
            status_now            = STAT_TIMEOUT;
          end else begin
            wait_elapsed_next = tick_next[TIMEOUT_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // history RAM
  bhp_history_ram #(
    .DEPTH  (HISTORY_DEPTH),
    .WIDTH  (8),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (stored_count[ADDR_W-1:0]),
    .wr_data (item.char_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // window renderer
  bhp_render u_render (
    .clk       (clk),
    .rst       (rst),
    .start     (rend_start),
    .start_idx (window_start_next[IDX_W-1:0]),
    .count     (stored_count),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .done      (rend_done),
    .pattern   (rend_pattern)
  );

  // sequencer and pager state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      stored_count     <= '0;
      window_start     <= WS_RESET;
      display_blanked  <= 1'b0;
      waiting_for_data <= 1'b0;
      wait_elapsed     <= '0;
      shown_pattern    <= '0;
      result_valid     <= 1'b0;
    end else begin
      // result valid: load a new result or drop the taken one
      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            stored_count     <= stored_count_next;
            window_start     <= window_start_next;
            display_blanked  <= display_blanked_next;
            waiting_for_data <= waiting_for_data_next;
            wait_elapsed     <= wait_elapsed_next;
            if (clear_pattern) begin
              shown_pattern <= '0;
            end
            state <= draw_now ? ST_DRAW : ST_DONE;
          end
        end
        ST_DRAW: begin
          if (rend_done) begin
            shown_pattern <= rend_pattern;
            state         <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // per-request result flags
  always_ff @(posedge clk) begin
    if (accept) begin
      res_update  <= update_now;
      res_status  <= status_now;
      res_request <= request_now;
    end else if (state == ST_DRAW && rend_done) begin
      res_update <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      result.dot_pattern    <= shown_pattern;
      result.pattern_update <= res_update;
      result.status_code    <= res_status;
      result.rescan_request <= res_request;
      result.rescan_pending <= waiting_for_data;
    end
  end

  // timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bhp_checker.sv */
// ----------------------------------------------------------------------------
// bhp_checker
// Port-level checks for the Braille history pager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bhp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          item_valid,
  input wire logic                          item_stall,
  input wire logic                          result_valid,
  input wire logic                          result_stall,
  input wire bhp_pkg::result_t              result
);

  import bhp_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("request accepted while busy");

  // a rescan blanks the display and starts the wait
  a_rescan_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.rescan_request |->
      result.rescan_pending && result.pattern_update && (result.dot_pattern == '0))
    else $error("rescan result inconsistent");

  // a clear always writes an empty pattern
  a_cleared_blank: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status_code == STAT_CLEARED) |->
      result.pattern_update && (result.dot_pattern == '0))
    else $error("clear did not blank the display");

  // end of a wait leaves nothing pending
  a_wait_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((result.status_code == STAT_TIMEOUT) ||
                     (result.status_code == STAT_RESCAN_DONE)) |->
      !result.rescan_pending)
    else $error("wait still pending after it ended");

endmodule

bind braille_history_pager_unit bhp_checker u_bhp_checker (.*);

`default_nettype wire
